### hw/rtl/c2dc_pkg.sv
// shared constants, command codes and controller/datapath interface types
// for the circular 2d convolution block; no dependencies
package c2dc_pkg;

    // input item field widths
    localparam int CMD_W     = 2;
    localparam int COORD_W   = 8;
    localparam int PIX_W     = 8;
    localparam int COEF_W    = 8;
    localparam int OUT_W     = 22;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 9;
    localparam int MSZ_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_SIDE  = 2'd2;

    localparam logic [CFG_W-1:0] RST_IMAGE_ROWS = 9'd256;
    localparam logic [CFG_W-1:0] RST_IMAGE_COLS = 9'd256;
    localparam logic [MSZ_W-1:0] RST_MASK_SIDE  = 4'd3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WR_COEF = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_PIX  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    // default store sizes
    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_MASK = 8;

    typedef struct packed {
        logic wr_coef;    // store coefficient from the accepted item
        logic wr_pix;     // store pixel from the accepted item
        logic mod_start;  // latch row/col and clear the remainders
        logic mod_step;   // one remainder bit step
        logic tap_init;   // load wrapped start position, clear accumulator
        logic tap_issue;  // read one tap and advance the position
        logic load_out;   // copy accumulator into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic last_tap;   // current tap is the last of the mask
        logic pipe_busy;  // taps still in the multiply-accumulate pipe
    } t_dp_status;

endpackage

### hw/rtl/c2dc_ctrl.sv
// controller state machine: input/output handshakes and command sequencing
// depends on c2dc_pkg
module c2dc_ctrl
    import c2dc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [CMD_W-1:0] i_cmd,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  t_dp_status       i_status,
    output t_dp_cmd          o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MOD    = 3'd1;
    localparam logic [2:0] S_INIT   = 3'd2;
    localparam logic [2:0] S_RUN    = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    localparam int CNT_W = (COORD_W > 1) ? $clog2(COORD_W) : 1;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             in_xfer;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd.wr_coef = (i_cmd == CMD_WR_COEF);
                    o_cmd.wr_pix  = (i_cmd == CMD_WR_PIX);
                    if (i_cmd == CMD_COMPUTE) begin
                        o_cmd.mod_start = 1'b1;
                        n_cnt           = '0;
                        n_state         = S_MOD;
                    end
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(COORD_W - 1)) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.tap_init = 1'b1;
                n_state        = S_RUN;
            end
            S_RUN: begin
                o_cmd.tap_issue = 1'b1;
                if (i_status.last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                // output register free or emptied in this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hw/rtl/c2dc_datapath.sv
// datapath: configuration registers, image and coefficient memories,
// bit-serial remainder, wrapped tap walk and multiply-accumulate pipe; uses c2dc_pkg
module c2dc_datapath
    import c2dc_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_MASK = DEF_MAX_MASK
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic [COORD_W-1:0]      i_row,
    input  logic [COORD_W-1:0]      i_col,
    input  logic [PIX_W-1:0]        i_pixel_value,
    input  logic signed [COEF_W-1:0] i_coeff_value,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    output logic signed [OUT_W-1:0] o_filtered_value
);

    localparam int RW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int MW     = (MAX_MASK > 1) ? $clog2(MAX_MASK) : 1;
    localparam int MSW    = $clog2(MAX_MASK + 1);
    localparam int PROD_W = PIX_W + 1 + COEF_W;

    // configuration
    logic [CFG_W-1:0] r_rows, r_cols;
    logic [MSZ_W-1:0] r_msz;
    logic [CFG_W-1:0] nr, nc;
    logic [MSW-1:0]   ms;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= RST_IMAGE_ROWS;
            r_cols <= RST_IMAGE_COLS;
            r_msz  <= RST_MASK_SIDE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_ROWS: r_rows <= i_cfg_data;
                CFG_IMAGE_COLS: r_cols <= i_cfg_data;
                CFG_MASK_SIDE:  r_msz  <= i_cfg_data[MSZ_W-1:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, too large acts as the store size
    always_comb begin
        nr = (r_rows == '0) ? CFG_W'(1)
           : ((32'(r_rows) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : r_rows);
        nc = (r_cols == '0) ? CFG_W'(1)
           : ((32'(r_cols) > MAX_COLS) ? CFG_W'(MAX_COLS) : r_cols);
        ms = (r_msz == '0) ? MSW'(1)
           : ((32'(r_msz) > MAX_MASK) ? MSW'(MAX_MASK) : MSW'(r_msz));
    end

    // memories
    logic [PIX_W-1:0]         image_mem [2**(RW+CW)];
    logic signed [COEF_W-1:0] coeff_mem [2**(2*MW)];
    logic [PIX_W-1:0]         r_pix;
    logic signed [COEF_W-1:0] r_coef;

    logic [RW-1:0] r_a;
    logic [CW-1:0] r_b, r_b0;
    logic [MW-1:0] r_k, r_l;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_pix && (32'(i_row) < MAX_ROWS) && (32'(i_col) < MAX_COLS)) begin
            image_mem[{RW'(i_row), CW'(i_col)}] <= i_pixel_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_issue) begin
            r_pix <= image_mem[{r_a, r_b}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_coef && (32'(i_row) < MAX_MASK) && (32'(i_col) < MAX_MASK)) begin
            coeff_mem[{MW'(i_row), MW'(i_col)}] <= i_coeff_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_issue) begin
            r_coef <= coeff_mem[{r_k, r_l}];
        end
    end

    // restoring remainder of row and col, one bit per step
    logic [COORD_W-1:0] r_rsh, r_csh;
    logic [CFG_W-1:0]   r_rrem, r_crem;
    logic [CFG_W:0]     rtry, ctry;

    assign rtry = {r_rrem, r_rsh[COORD_W-1]};
    assign ctry = {r_crem, r_csh[COORD_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_start) begin
            r_rsh  <= i_row;
            r_csh  <= i_col;
            r_rrem <= '0;
            r_crem <= '0;
        end else if (i_cmd.mod_step) begin
            r_rsh  <= r_rsh << 1;
            r_csh  <= r_csh << 1;
            r_rrem <= (rtry >= {1'b0, nr}) ? CFG_W'(rtry - {1'b0, nr}) : CFG_W'(rtry);
            r_crem <= (ctry >= {1'b0, nc}) ? CFG_W'(ctry - {1'b0, nc}) : CFG_W'(ctry);
        end
    end

    // tap walk with wrap by one compare
    logic last_l, last_k;
    logic [RW-1:0] a_inc;
    logic [CW-1:0] b_inc;

    assign last_l = (32'(r_l) + 1 == 32'(ms));
    assign last_k = (32'(r_k) + 1 == 32'(ms));
    assign a_inc  = (32'(r_a) + 1 >= 32'(nr)) ? '0 : r_a + 1'b1;
    assign b_inc  = (32'(r_b) + 1 >= 32'(nc)) ? '0 : r_b + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_init) begin
            r_a  <= RW'(r_rrem);
            r_b  <= CW'(r_crem);
            r_b0 <= CW'(r_crem);
            r_k  <= '0;
            r_l  <= '0;
        end else if (i_cmd.tap_issue) begin
            if (last_l) begin
                r_l <= '0;
                r_b <= r_b0;
                r_k <= r_k + 1'b1;
                r_a <= a_inc;
            end else begin
                r_l <= r_l + 1'b1;
                r_b <= b_inc;
            end
        end
    end

    // multiply-accumulate pipe
    logic                     r_v1, r_v2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [OUT_W-1:0]  r_acc;
    logic signed [OUT_W-1:0]  r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.tap_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= $signed({1'b0, r_pix}) * r_coef;
        end
        if (i_cmd.tap_init) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + {{(OUT_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
        end
        if (i_cmd.load_out) begin
            r_out <= r_acc;
        end
    end

    assign o_status.last_tap  = last_l && last_k;
    assign o_status.pipe_busy = r_v1 || r_v2;
    assign o_filtered_value   = r_out;

endmodule

### hw/rtl/circular_2d_convolution_top.sv
// top level of the circular 2d convolution block
// instantiates c2dc_ctrl and c2dc_datapath; uses c2dc_pkg
//
// Write items (coefficient or pixel) leave the controller idle, so the next item
// can be taken straight after. A compute item passes these steps from its transfer
// to a valid result, and the next item can be taken in the same cycle that the
// result becomes valid: eight bit-serial remainder steps bring row and col into
// the image, an init state loads the wrapped start position, then one tap per
// cycle through the single image memory read port, the read, multiply and
// accumulate pipe drains and the result is loaded into an output register, so
// the next item is taken while it waits; a compute item only stalls at its end
// if the previous result has not yet been taken. Coefficients and pixels read
// before they are written give undefined values; there is no clearing pass.
// Configuration writes are taken in any cycle and must be made while idle.
module circular_2d_convolution_top
    import c2dc_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_MASK = DEF_MAX_MASK
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic [COORD_W-1:0]       i_row,
    input  logic [COORD_W-1:0]       i_col,
    input  logic [PIX_W-1:0]         i_pixel_value,
    input  logic signed [COEF_W-1:0] i_coeff_value,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [OUT_W-1:0]  o_filtered_value
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    c2dc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    c2dc_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .MAX_MASK (MAX_MASK)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_pixel_value    (i_pixel_value),
        .i_coeff_value    (i_coeff_value),
        .i_cmd            (dp_cmd),
        .o_status         (dp_status),
        .o_filtered_value (o_filtered_value)
    );

endmodule
